// ===== rtl/assert_macros.svh =====
// Assertion helpers; clock and reset are passed explicitly at each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: invariant violated");

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication violated");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication violated");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/rpq_pkg.sv =====
package rpq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int ID_W      = 8;
    localparam int PRIO_W    = 8;
    localparam int QUANTUM_W = 8;
    localparam int COUNT_W   = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 8;

    localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = QUANTUM_W'(3);

    typedef enum logic [1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_TICK    = 2'd1,
        CMD_PICK    = 2'd2,
        CMD_STEAL   = 2'd3
    } cmd_t;

    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PREEMPT = CFG_IDX_W'(1);

    typedef struct packed {
        cmd_t              cmd;
        logic [ID_W-1:0]   task_id;
        logic [PRIO_W-1:0] prio;
        logic              front_request;
        logic              preempted;
        logic              is_idle;
    } req_t;

    typedef struct packed {
        logic [ID_W-1:0]    out_task;
        logic               out_valid;
        logic               resched_req;
        logic [COUNT_W-1:0] queue_count;
        logic               dropped;
    } rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
    } ctrl_t;

endpackage

// ===== rtl/rpq_ctrl.sv =====
`include "assert_macros.svh"

module rpq_ctrl
    import rpq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    output logic  req_ready,
    output logic  rsp_valid,
    input  logic  rsp_ready,
    output ctrl_t ctrl
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_OUT  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Take the next request in the same cycle the result leaves
    assign req_ready = (state_reg == S_IDLE) || ((state_reg == S_OUT) && rsp_ready);
    assign rsp_valid = (state_reg == S_OUT);
    assign ctrl.load = req_valid && req_ready;
    assign ctrl.exec = (state_reg == S_EXEC);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (rsp_ready)
                begin
                    state_next = req_valid ? S_EXEC : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `ASSERT_NEXT(a_load_then_exec, clk, rst_n, ctrl.load, ctrl.exec)
    `ASSERT_NEXT(a_exec_then_result, clk, rst_n, ctrl.exec, rsp_valid)
    `ASSERT_IMPLIES(a_no_load_on_stall, clk, rst_n, req_ready && rsp_valid, rsp_ready)

endmodule

// ===== rtl/rpq_datapath.sv =====
`include "assert_macros.svh"

module rpq_datapath
    import rpq_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctrl_t                ctrl,
    input  req_t                 req,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output rsp_t                 rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);

    req_t req_reg;
    rsp_t rsp_reg;
    rsp_t rsp_next;

    // Sorted cell row, head at cell 0
    logic [ID_W-1:0]   ids_reg   [DEPTH];
    logic [PRIO_W-1:0] prios_reg [DEPTH];
    logic [ID_W-1:0]   ids_next  [DEPTH];
    logic [PRIO_W-1:0] prios_next[DEPTH];

    logic [CNT_W-1:0]     count_reg, count_next;
    logic [PRIO_W-1:0]    running_prio_reg, running_prio_next;
    logic                 running_idle_reg, running_idle_next;
    logic [QUANTUM_W-1:0] slice_reg, slice_next;
    logic                 resched_reg, resched_next;
    logic                 mark_reg, mark_next;
    logic [QUANTUM_W-1:0] quantum_reg;
    logic                 preempt_en_reg;

    logic             use_front;
    logic             full;
    logic [DEPTH-1:0] keep;
    logic [IDX_W-1:0] tail_idx;

    assign use_front = req_reg.front_request || (req_reg.preempted && mark_reg);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign tail_idx  = IDX_W'(count_reg - CNT_W'(1));

    // Each live cell decides whether it stays ahead of the new entry
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            keep[i] = (CNT_W'(i) < count_reg) &&
                      (use_front ? (prios_reg[i] < req_reg.prio)
                                 : (prios_reg[i] <= req_reg.prio));
        end
    end

    always_comb
    begin
        int up;
        int dn;

        up                = 0;
        dn                = 0;
        ids_next          = ids_reg;
        prios_next        = prios_reg;
        count_next        = count_reg;
        running_prio_next = running_prio_reg;
        running_idle_next = running_idle_reg;
        slice_next        = slice_reg;
        resched_next      = resched_reg;
        mark_next         = mark_reg;
        rsp_next          = '0;

        case (req_reg.cmd)
            CMD_ENQUEUE:
            begin
                if (!req_reg.is_idle)
                begin
                    if (full)
                    begin
                        rsp_next.dropped = 1'b1;
                    end
                    else
                    begin
                        for (int i = 0; i < DEPTH; i++)
                        begin
                            dn = (i == 0) ? 0 : i - 1;
                            if (keep[i])
                            begin
                                ids_next[i]   = ids_reg[i];
                                prios_next[i] = prios_reg[i];
                            end
                            else if (i == 0 || keep[IDX_W'(dn)])
                            begin
                                ids_next[i]   = req_reg.task_id;
                                prios_next[i] = req_reg.prio;
                            end
                            else
                            begin
                                ids_next[i]   = ids_reg[IDX_W'(dn)];
                                prios_next[i] = prios_reg[IDX_W'(dn)];
                            end
                        end
                        count_next = count_reg + CNT_W'(1);
                        if (req_reg.preempted)
                        begin
                            mark_next = 1'b0;
                        end
                        else if (preempt_en_reg && (req_reg.prio < running_prio_reg))
                        begin
                            resched_next = 1'b1;
                            if (!running_idle_reg)
                            begin
                                mark_next = 1'b1;
                            end
                        end
                    end
                end
            end
            CMD_TICK:
            begin
                if (!running_idle_reg)
                begin
                    // Saturate at zero; reaching or staying at zero asks to reschedule
                    if (slice_reg != '0)
                    begin
                        slice_next = slice_reg - QUANTUM_W'(1);
                    end
                    if (slice_reg <= QUANTUM_W'(1))
                    begin
                        resched_next = 1'b1;
                    end
                end
            end
            CMD_PICK:
            begin
                resched_next = 1'b0;
                mark_next    = 1'b0;
                if (count_reg != '0)
                begin
                    rsp_next.out_task  = ids_reg[0];
                    rsp_next.out_valid = 1'b1;
                    running_prio_next  = prios_reg[0];
                    running_idle_next  = 1'b0;
                    slice_next         = quantum_reg;
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        up = (i == DEPTH - 1) ? i : i + 1;
                        ids_next[i]   = ids_reg[IDX_W'(up)];
                        prios_next[i] = prios_reg[IDX_W'(up)];
                    end
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    running_idle_next = 1'b1;
                    running_prio_next = '0;
                    slice_next        = '0;
                end
            end
            CMD_STEAL:
            begin
                if (count_reg != '0)
                begin
                    rsp_next.out_task  = ids_reg[tail_idx];
                    rsp_next.out_valid = 1'b1;
                    count_next         = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                rsp_next = '0;
            end
        endcase

        rsp_next.resched_req = resched_next;
        rsp_next.queue_count = COUNT_W'(count_next);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            req_reg <= req;
        end
        if (ctrl.exec)
        begin
            ids_reg   <= ids_next;
            prios_reg <= prios_next;
            rsp_reg   <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            running_prio_reg <= '0;
            running_idle_reg <= 1'b1;
            slice_reg        <= '0;
            resched_reg      <= 1'b0;
            mark_reg         <= 1'b0;
            quantum_reg      <= QUANTUM_RESET;
            preempt_en_reg   <= 1'b1;
        end
        else
        begin
            if (ctrl.exec)
            begin
                count_reg        <= count_next;
                running_prio_reg <= running_prio_next;
                running_idle_reg <= running_idle_next;
                slice_reg        <= slice_next;
                resched_reg      <= resched_next;
                mark_reg         <= mark_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_QUANTUM: quantum_reg    <= cfg_data[QUANTUM_W-1:0];
                    CFG_PREEMPT: preempt_en_reg <= cfg_data[0];
                    default:     quantum_reg    <= quantum_reg;
                endcase
            end
        end
    end

    assign rsp = rsp_reg;

    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CNT_W'(DEPTH))
    `ASSERT_IMPLIES(a_idle_no_slice, clk, rst_n, running_idle_reg, slice_reg == '0)
    `ASSERT_IMPLIES(a_idle_no_mark, clk, rst_n, running_idle_reg, !mark_reg)

endmodule

// ===== rtl/priority_run_queue_with_quantum.sv =====
// Priority run queue with a round-robin quantum. Tasks wait in a row of
// DEPTH sorted cells (lower priority value first); each request (enqueue,
// tick, pick, steal) is registered on acceptance, applied to the cell row in
// the next cycle, and its response is presented the cycle after. A request is
// accepted in the same cycle that the previous response is taken, so the
// block works on one request at a time, and a response that is not taken
// holds off the next request. Configuration writes are always ready and
// take effect at once.
// No clearing pass follows reset: the cells are tracked by the fill count.
module priority_run_queue_with_quantum
    import rpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  req_t                 req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output rsp_t                 rsp,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    ctrl_t ctrl;

    assign cfg_ready = 1'b1;

    rpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .ctrl      (ctrl)
    );

    rpq_datapath #(
        .DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .req       (req),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rsp       (rsp)
    );

endmodule
